// ----- sv/coalescing_edge_update_buffer_assert.svh -----
// Assertion macros used by the checker file of the edge update buffer.
`ifndef COALESCING_EDGE_UPDATE_BUFFER_ASSERT_SVH
`define COALESCING_EDGE_UPDATE_BUFFER_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define CEWB_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("edge update buffer check failed");

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define CEWB_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("edge update buffer check failed");

`endif

// ----- sv/cewb_pkg.sv -----
// ----------------------------------------------------------------------------
// cewb_pkg
// Shared types and constants of the coalescing edge update buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package cewb_pkg;

  localparam int VERTEX_W      = 32;
  localparam int WEIGHT_W      = 32;
  localparam int SLOT_W        = 32;
  localparam int BUF_DEPTH_DEF = 32;

  // stream widths: input item fields, output item fields
  localparam int S_TDATA_W = 2 * VERTEX_W + WEIGHT_W;
  localparam int M_TDATA_W = 2 * VERTEX_W + WEIGHT_W + SLOT_W;

  // command codes carried on s_tuser
  localparam logic CMD_ENQUEUE = 1'b0;
  localparam logic CMD_FLUSH   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ENQ,
    ST_SCAN,
    ST_EMIT
  } state_t;

  // one buffered edge
  typedef struct packed {
    logic        [VERTEX_W-1:0] src;
    logic        [VERTEX_W-1:0] dst;
    logic signed [WEIGHT_W-1:0] weight;
  } entry_t;

  // sequencer commands to the merge unit
  typedef struct packed {
    logic flush_init;  // new flush: no group emitted yet
    logic take;        // read data valid this cycle
    logic emit;        // current group handed off, start next scan
  } merge_ctl_t;

  // merge unit result for the current group
  typedef struct packed {
    logic        [VERTEX_W-1:0] src;
    logic        [VERTEX_W-1:0] dst;
    logic signed [WEIGHT_W-1:0] weight;
    logic                       last;
  } merge_stat_t;

endpackage

`default_nettype wire

// ----- sv/cewb_entry_store.sv -----
// ----------------------------------------------------------------------------
// cewb_entry_store
// Buffer memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cewb_entry_store #(
  parameter int BUF_DEPTH = cewb_pkg::BUF_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [$clog2(BUF_DEPTH)-1:0] wr_addr,
  input  cewb_pkg::entry_t             wr_data,
  input  logic                         rd_en,
  input  logic [$clog2(BUF_DEPTH)-1:0] rd_addr,
  output cewb_pkg::entry_t             rd_data
);

  cewb_pkg::entry_t mem [BUF_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/cewb_merge_unit.sv -----
// ----------------------------------------------------------------------------
// cewb_merge_unit
// Shared compare/accumulate unit. Each scan over the buffer finds the
// smallest (src, dst) pair above the last emitted one and sums the weights
// of all entries holding that pair.
// ----------------------------------------------------------------------------
`default_nettype none

module cewb_merge_unit #(
  parameter int BUF_DEPTH = cewb_pkg::BUF_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  cewb_pkg::merge_ctl_t           ctl,
  input  cewb_pkg::entry_t               rd_data,
  input  logic [$clog2(BUF_DEPTH+1)-1:0] fill,
  output cewb_pkg::merge_stat_t          stat
);

  localparam int CW    = $clog2(BUF_DEPTH + 1);
  localparam int ACC_W = cewb_pkg::WEIGHT_W + $clog2(BUF_DEPTH) + 1;
  localparam int VW    = cewb_pkg::VERTEX_W;
  localparam int WW    = cewb_pkg::WEIGHT_W;

  logic                    found;
  logic                    bound_vld;
  logic [VW-1:0]           bound_src;
  logic [VW-1:0]           bound_dst;
  logic [VW-1:0]           min_src;
  logic [VW-1:0]           min_dst;
  logic signed [ACC_W-1:0] acc;
  logic [CW-1:0]           gcnt;
  logic [CW-1:0]           consumed;

  logic                    above;
  logic                    below_min;
  logic                    eq_min;
  logic signed [ACC_W-1:0] acc_sum;
  logic [CW-1:0]           consumed_next;
  logic                    acc_ovf;

  // pair compares against the bound and the running minimum
  always_comb begin
    above = !bound_vld ||
            (rd_data.src > bound_src) ||
            ((rd_data.src == bound_src) && (rd_data.dst > bound_dst));
    below_min = (rd_data.src < min_src) ||
                ((rd_data.src == min_src) && (rd_data.dst < min_dst));
    eq_min  = (rd_data.src == min_src) && (rd_data.dst == min_dst);
    acc_sum = acc + ACC_W'(rd_data.weight);
  end

  // scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      found     <= 1'b0;
      bound_vld <= 1'b0;
      gcnt      <= '0;
      consumed  <= '0;
    end else if (ctl.flush_init) begin
      found     <= 1'b0;
      bound_vld <= 1'b0;
      gcnt      <= '0;
      consumed  <= '0;
    end else if (ctl.emit) begin
      found     <= 1'b0;
      bound_vld <= 1'b1;
      bound_src <= min_src;
      bound_dst <= min_dst;
      consumed  <= consumed_next;
      gcnt      <= '0;
    end else if (ctl.take && above) begin
      if (!found || below_min) begin
        found   <= 1'b1;
        min_src <= rd_data.src;
        min_dst <= rd_data.dst;
        acc     <= ACC_W'(rd_data.weight);
        gcnt    <= CW'(1);
      end else if (eq_min) begin
        acc  <= acc_sum;
        gcnt <= gcnt + CW'(1);
      end
    end
  end

  // group result with saturation to the signed weight range
  always_comb begin
    consumed_next = consumed + gcnt;
    acc_ovf       = !((&acc[ACC_W-1:WW-1]) || (~|acc[ACC_W-1:WW-1]));
    stat.src      = min_src;
    stat.dst      = min_dst;
    stat.last     = (consumed_next == fill);
    if (acc_ovf) begin
      stat.weight = acc[ACC_W-1] ? {1'b1, {(WW-1){1'b0}}} : {1'b0, {(WW-1){1'b1}}};
    end else begin
      stat.weight = acc[WW-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- sv/coalescing_edge_update_buffer.sv -----
// An enqueue is accepted in ST_IDLE, then in ST_ENQ compared with the newest
// entry and written to the buffer. A flush of n buffered entries that merge
// into g distinct (src, dst) pairs takes g scans over all n entries, each
// followed by one emitted item, since the single read port of the buffer
// memory feeds one compare/accumulate unit. Results leave in ascending
// (src, dst) order. An enqueue on a full buffer that does not match the
// newest entry flushes the old contents first, then stores the new edge. The
// block accepts no input item while a flush is in progress.
// ----------------------------------------------------------------------------
// coalescing_edge_update_buffer
// Coalescing buffer of weighted edge updates with sort-and-merge flush.
// ----------------------------------------------------------------------------
`default_nettype none

module coalescing_edge_update_buffer #(
  parameter int BUF_DEPTH = cewb_pkg::BUF_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // input items
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [cewb_pkg::S_TDATA_W-1:0] s_tdata,  // src_vertex, dst_vertex, edge_weight
  input  logic                           s_tuser,  // cmd
  // result items
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [cewb_pkg::M_TDATA_W-1:0] m_tdata,  // out_src, out_dst, out_weight, out_slot
  output logic                           m_tlast   // out_last
);

  localparam int CW = $clog2(BUF_DEPTH + 1);
  localparam int AW = $clog2(BUF_DEPTH);
  localparam int VW = cewb_pkg::VERTEX_W;
  localparam int WW = cewb_pkg::WEIGHT_W;
  localparam int SW = cewb_pkg::SLOT_W;

  cewb_pkg::state_t      state;
  cewb_pkg::state_t      state_next;

  logic [CW-1:0]         fill;
  logic [SW-1:0]         next_slot;
  logic                  cmd_r;
  cewb_pkg::entry_t      item;
  cewb_pkg::entry_t      newest;
  logic [CW-1:0]         scan_cnt;
  logic                  rd_vld;

  logic                  s_acc;
  logic                  m_acc;
  logic                  match;
  logic                  room;
  logic signed [WW:0]    wsum;
  logic signed [WW-1:0]  wsum_sat;
  logic                  scan_done;

  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  cewb_pkg::entry_t      wr_data;
  logic                  rd_en;
  cewb_pkg::entry_t      rd_data;
  cewb_pkg::merge_ctl_t  mctl;
  cewb_pkg::merge_stat_t mstat;

  // datapath conditions
  always_comb begin
    s_acc     = s_tvalid && s_tready;
    m_acc     = m_tvalid && m_tready;
    match     = (fill != '0) && (newest.src == item.src) && (newest.dst == item.dst);
    room      = (fill < CW'(BUF_DEPTH));
    wsum      = {newest.weight[WW-1], newest.weight} + {item.weight[WW-1], item.weight};
    wsum_sat  = (wsum[WW] != wsum[WW-1]) ?
                (wsum[WW] ? {1'b1, {(WW-1){1'b0}}} : {1'b0, {(WW-1){1'b1}}}) :
                wsum[WW-1:0];
    scan_done = (scan_cnt == fill) && !rd_vld;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      cewb_pkg::ST_IDLE: begin
        if (s_acc) begin
          if (s_tuser == cewb_pkg::CMD_FLUSH) begin
            state_next = (fill == '0) ? cewb_pkg::ST_IDLE : cewb_pkg::ST_SCAN;
          end else begin
            state_next = cewb_pkg::ST_ENQ;
          end
        end
      end
      cewb_pkg::ST_ENQ: begin
        state_next = (match || room) ? cewb_pkg::ST_IDLE : cewb_pkg::ST_SCAN;
      end
      cewb_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_next = cewb_pkg::ST_EMIT;
        end
      end
      cewb_pkg::ST_EMIT: begin
        if (m_acc) begin
          if (!mstat.last) begin
            state_next = cewb_pkg::ST_SCAN;
          end else if (cmd_r == cewb_pkg::CMD_ENQUEUE) begin
            state_next = cewb_pkg::ST_ENQ;
          end else begin
            state_next = cewb_pkg::ST_IDLE;
          end
        end
      end
      default: state_next = cewb_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_tready        = (state == cewb_pkg::ST_IDLE);
    wr_en           = (state == cewb_pkg::ST_ENQ) && (match || room);
    wr_addr         = match ? AW'(fill - CW'(1)) : AW'(fill);
    wr_data         = item;
    if (match) begin
      wr_data.weight = wsum_sat;
    end
    rd_en           = (state == cewb_pkg::ST_SCAN) && (scan_cnt < fill);
    mctl.flush_init = ((state == cewb_pkg::ST_IDLE) && (state_next == cewb_pkg::ST_SCAN)) ||
                      ((state == cewb_pkg::ST_ENQ) && (state_next == cewb_pkg::ST_SCAN));
    mctl.take       = rd_vld;
    mctl.emit       = (state == cewb_pkg::ST_EMIT) && m_acc;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cewb_pkg::ST_IDLE;
      fill      <= '0;
      next_slot <= '0;
      scan_cnt  <= '0;
      rd_vld    <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= rd_en;
      // read address sweep, restarted on every scan
      if (state == cewb_pkg::ST_SCAN) begin
        if (rd_en) begin
          scan_cnt <= scan_cnt + CW'(1);
        end
      end else begin
        scan_cnt <= '0;
      end
      // buffer fill on enqueue
      if ((state == cewb_pkg::ST_ENQ) && !match && room) begin
        fill <= fill + CW'(1);
      end
      // output register handshake
      if ((state == cewb_pkg::ST_SCAN) && scan_done) begin
        m_tvalid <= 1'b1;
      end else if (m_acc) begin
        m_tvalid  <= 1'b0;
        next_slot <= next_slot + SW'(1);
        if (mstat.last) begin
          fill <= '0;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_acc) begin
      cmd_r       <= s_tuser;
      item.src    <= s_tdata[VW-1:0];
      item.dst    <= s_tdata[2*VW-1:VW];
      item.weight <= s_tdata[2*VW+WW-1:2*VW];
    end
    // copy of the newest buffered entry
    if (state == cewb_pkg::ST_ENQ) begin
      if (match) begin
        newest.weight <= wsum_sat;
      end else if (room) begin
        newest <= item;
      end
    end
    if ((state == cewb_pkg::ST_SCAN) && scan_done) begin
      m_tdata <= {next_slot, mstat.weight, mstat.dst, mstat.src};
      m_tlast <= mstat.last;
    end
  end

  cewb_entry_store #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (scan_cnt[AW-1:0]),
    .rd_data (rd_data)
  );

  cewb_merge_unit #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_merge (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mctl),
    .rd_data (rd_data),
    .fill    (fill),
    .stat    (mstat)
  );

endmodule

`default_nettype wire

// ----- sv/cewb_checker.sv -----
// ----------------------------------------------------------------------------
// cewb_checker
// Port-level checks of the edge update buffer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "coalescing_edge_update_buffer_assert.svh"

module cewb_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           s_tvalid,
  input wire logic                           s_tready,
  input wire logic                           s_tuser,
  input wire logic                           m_tvalid,
  input wire logic                           m_tready,
  input wire logic [cewb_pkg::M_TDATA_W-1:0] m_tdata,
  input wire logic                           m_tlast
);

  // a stalled result item holds
  `CEWB_ASSERT_NXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

  // no input item is taken while a result item waits
  `CEWB_ASSERT_IMP(a_no_accept_on_emit, clk, rst, m_tvalid, !s_tready)

  // an enqueue keeps the input side closed for its write cycle
  `CEWB_ASSERT_NXT(a_enq_busy, clk, rst, s_tvalid && s_tready && (s_tuser == cewb_pkg::CMD_ENQUEUE), !s_tready)

  // a flush that is not finished keeps the input side closed
  `CEWB_ASSERT_NXT(a_flush_busy, clk, rst, m_tvalid && m_tready && !m_tlast, !s_tready)

  // nothing is offered right after reset
  `CEWB_ASSERT_IMP(a_reset_quiet, clk, rst, $past(rst), !m_tvalid)

endmodule

bind coalescing_edge_update_buffer cewb_checker u_cewb_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire

// ----- tb/sv/coalescing_edge_update_buffer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coalescing_edge_update_buffer_tb
// Self-checking bench for the coalescing edge update buffer. A directed table
// covers the corner cases: empty flush, coalescing saturation, unsigned sort
// order, exact group sums and overflow flushes. It is followed by random
// batches of enqueues over small pools of edge pairs, with flushes between
// them. Every emitted edge is compared with a local sort-and-merge predictor,
// or with the expected edge written in its directed row. The input and output
// sides idle in several phases, and one long output hold-off fills the buffer.
// ----------------------------------------------------------------------------

module coalescing_edge_update_buffer_tb;

  localparam int DEPTH        = cewb_pkg::BUF_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 310;
  localparam int HOLD_LEN     = 600;
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT  = 3000000;

  localparam logic signed [cewb_pkg::WEIGHT_W-1:0] W_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [cewb_pkg::WEIGHT_W-1:0] W_MIN = 32'sh8000_0000;

  // one merged edge as it leaves the block
  typedef struct packed {
    logic        [cewb_pkg::VERTEX_W-1:0] src;
    logic        [cewb_pkg::VERTEX_W-1:0] dst;
    logic signed [cewb_pkg::WEIGHT_W-1:0] weight;
    logic        [cewb_pkg::SLOT_W-1:0]   slot;
    logic                                 last;
  } merged_edge_t;

  // directed row: reps > 1 walks src down and dst, weight up per item
  typedef struct packed {
    logic                                 cmd;
    logic        [cewb_pkg::VERTEX_W-1:0] src;
    logic        [cewb_pkg::VERTEX_W-1:0] dst;
    logic signed [cewb_pkg::WEIGHT_W-1:0] weight;
    logic        [7:0]                    reps;
    logic                                 typed;
    merged_edge_t                         want;
  } plan_row_t;

  localparam merged_edge_t NONE = '0;
  localparam int PLAN_LEN = 24;

  localparam plan_row_t PLAN [PLAN_LEN] = '{
    // flush of an empty buffer, fields ignored
    '{cewb_pkg::CMD_FLUSH,   32'hFFFF_FFFF, 32'hFFFF_FFFF, W_MAX,    8'd1,  1'b0, NONE},
    // single zero edge
    '{cewb_pkg::CMD_ENQUEUE, 32'h0,         32'h0,         32'sh0,   8'd1,  1'b0, NONE},
    '{cewb_pkg::CMD_FLUSH,   32'h1234_5678, 32'h9ABC_DEF0, W_MIN,    8'd1,  1'b1,
      '{32'h0, 32'h0, 32'sh0, 32'd0, 1'b1}},
    // coalescing saturates high
    '{cewb_pkg::CMD_ENQUEUE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, W_MAX,    8'd1,  1'b0, NONE},
    '{cewb_pkg::CMD_ENQUEUE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'sh1,   8'd1,  1'b0, NONE},
    '{cewb_pkg::CMD_FLUSH,   32'h0,         32'h0,         32'sh0,   8'd1,  1'b1,
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, W_MAX, 32'd1, 1'b1}},
    // coalescing saturates low
    '{cewb_pkg::CMD_ENQUEUE, 32'h5,         32'h6,         W_MIN,    8'd1,  1'b0, NONE},
    '{cewb_pkg::CMD_ENQUEUE, 32'h5,         32'h6,         -32'sh1,  8'd1,  1'b0, NONE},
    '{cewb_pkg::CMD_FLUSH,   32'h0,         32'h0,         32'sh0,   8'd1,  1'b1,
      '{32'h5, 32'h6, W_MIN, 32'd2, 1'b1}},
    // unsigned order on src, then dst
    '{cewb_pkg::CMD_ENQUEUE, 32'h8000_0000, 32'h0,         32'sd10,  8'd1,  1'b0, NONE},
    '{cewb_pkg::CMD_ENQUEUE, 32'h1,         32'hFFFF_FFFF, 32'sd20,  8'd1,  1'b0, NONE},
    '{cewb_pkg::CMD_ENQUEUE, 32'h1,         32'h0,         32'sd30,  8'd1,  1'b0, NONE},
    '{cewb_pkg::CMD_FLUSH,   32'h0,         32'h0,         32'sh0,   8'd1,  1'b0, NONE},
    // group sum taken exactly, saturated once
    '{cewb_pkg::CMD_ENQUEUE, 32'h9,         32'h9,         W_MAX,    8'd1,  1'b0, NONE},
    '{cewb_pkg::CMD_ENQUEUE, 32'h1,         32'h2,         32'sd3,   8'd1,  1'b0, NONE},
    '{cewb_pkg::CMD_ENQUEUE, 32'h9,         32'h9,         W_MAX,    8'd1,  1'b0, NONE},
    '{cewb_pkg::CMD_ENQUEUE, 32'h1,         32'h2,         -32'sd5,  8'd1,  1'b0, NONE},
    '{cewb_pkg::CMD_ENQUEUE, 32'h9,         32'h9,         W_MIN,    8'd1,  1'b0, NONE},
    '{cewb_pkg::CMD_ENQUEUE, 32'h4,         32'h4,         W_MIN,    8'd1,  1'b0, NONE},
    '{cewb_pkg::CMD_ENQUEUE, 32'h4,         32'h5,         32'sh0,   8'd1,  1'b0, NONE},
    '{cewb_pkg::CMD_ENQUEUE, 32'h4,         32'h4,         W_MIN,    8'd1,  1'b0, NONE},
    '{cewb_pkg::CMD_FLUSH,   32'h0,         32'h0,         32'sh0,   8'd1,  1'b0, NONE},
    // fill in descending order, one past full forces a flush
    '{cewb_pkg::CMD_ENQUEUE, 32'hFFFF_FFF0, 32'h0,         -32'sd16, 8'd33, 1'b0, NONE},
    '{cewb_pkg::CMD_FLUSH,   32'h0,         32'h0,         32'sh0,   8'd1,  1'b0, NONE}
  };

  logic                           clk      = 1'b0;
  logic                           rst      = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [cewb_pkg::S_TDATA_W-1:0] s_tdata  = '0;
  logic                           s_tuser  = cewb_pkg::CMD_ENQUEUE;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [cewb_pkg::M_TDATA_W-1:0] m_tdata;
  logic                           m_tlast;

  // predictor state
  cewb_pkg::entry_t               edge_buf [DEPTH];
  int                             fill_cnt  = 0;
  logic [cewb_pkg::SLOT_W-1:0]    slot_next = '0;
  merged_edge_t                   flushed_edges[$];
  merged_edge_t                   expected_edges[$];

  // idling controls: rates and hold request set by the stimulus, hold ack and countdown by the output side
  int send_idle_pct = 26;
  int rcv_stall_pct = 26;
  int hold_req      = 0;
  int hold_ack      = 0;
  int hold_left     = 0;

  int n_items       = 0;
  int n_checked     = 0;
  int n_errors      = 0;
  int n_flush_cmd   = 0;
  int n_coalesced   = 0;
  int n_overflow    = 0;
  int n_cycles      = 0;

  coalescing_edge_update_buffer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // src_vertex, dst_vertex, edge_weight
    .s_tuser  (s_tuser),   // cmd
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // out_src, out_dst, out_weight, out_slot
    .m_tlast  (m_tlast)    // out_last
  );

  always #4 clk = ~clk;

  function automatic void log_error(string msg);
    n_errors++;
    if (n_errors <= 10) $display("ERROR @%0t: %s", $time, msg);
  endfunction

  function automatic logic signed [cewb_pkg::WEIGHT_W-1:0] clamp32(longint v);
    if (v > longint'(W_MAX)) return W_MAX;
    if (v < longint'(W_MIN)) return W_MIN;
    return v[cewb_pkg::WEIGHT_W-1:0];
  endfunction

  // sort by (src, dst), sum equal pairs, emit with running slots
  function automatic void sort_and_merge();
    cewb_pkg::entry_t e;
    merged_edge_t     r;
    int               k;
    int               cnt;
    longint           acc;
    if (fill_cnt == 0) return;
    for (int i = 1; i < fill_cnt; i++) begin
      e = edge_buf[i];
      k = i;
      while (k > 0 && (e.src < edge_buf[k-1].src ||
                       (e.src == edge_buf[k-1].src && e.dst < edge_buf[k-1].dst))) begin
        edge_buf[k] = edge_buf[k-1];
        k--;
      end
      edge_buf[k] = e;
    end
    cnt = 0;
    acc = $signed(edge_buf[0].weight);
    for (int i = 1; i <= fill_cnt; i++) begin
      if (i < fill_cnt && edge_buf[i].src == edge_buf[i-1].src &&
          edge_buf[i].dst == edge_buf[i-1].dst) begin
        acc += $signed(edge_buf[i].weight);
      end else begin
        r.src    = edge_buf[i-1].src;
        r.dst    = edge_buf[i-1].dst;
        r.weight = clamp32(acc);
        r.slot   = slot_next + cnt;
        r.last   = (i == fill_cnt);
        flushed_edges.push_back(r);
        cnt++;
        if (i < fill_cnt) acc = $signed(edge_buf[i].weight);
      end
    end
    slot_next += cnt;
    fill_cnt   = 0;
  endfunction

  function automatic void predict(logic cmd, logic [cewb_pkg::VERTEX_W-1:0] s,
                                  logic [cewb_pkg::VERTEX_W-1:0] d,
                                  logic signed [cewb_pkg::WEIGHT_W-1:0] w);
    flushed_edges.delete();
    if (cmd == cewb_pkg::CMD_FLUSH) begin
      n_flush_cmd++;
      sort_and_merge();
      return;
    end
    // same pair as the newest entry: accumulate in place
    if (fill_cnt > 0 && edge_buf[fill_cnt-1].src == s && edge_buf[fill_cnt-1].dst == d) begin
      edge_buf[fill_cnt-1].weight =
        clamp32(longint'($signed(edge_buf[fill_cnt-1].weight)) + longint'(w));
      n_coalesced++;
      return;
    end
    if (fill_cnt == DEPTH) begin
      n_overflow++;
      sort_and_merge();
    end
    edge_buf[fill_cnt] = '{s, d, w};
    fill_cnt++;
  endfunction

  // predict, queue the expectation, then hand the item over
  task automatic send_edge(logic cmd, logic [cewb_pkg::VERTEX_W-1:0] s,
                           logic [cewb_pkg::VERTEX_W-1:0] d,
                           logic signed [cewb_pkg::WEIGHT_W-1:0] w, logic typed,
                           merged_edge_t want);
    predict(cmd, s, d, w);
    if (typed) expected_edges.push_back(want);
    else expected_edges = {expected_edges, flushed_edges};
    n_items++;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {w, d, s};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  function automatic logic [cewb_pkg::VERTEX_W-1:0] pick_id();
    case ($urandom_range(3))
      0:       return $urandom_range(7);
      1:       return 32'hFFFF_FFFF - $urandom_range(7);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic signed [cewb_pkg::WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(9))
      0:          return W_MAX;
      1:          return W_MIN;
      2, 3, 4, 5: return int'($urandom_range(200)) - 100;
      default:    return $urandom();
    endcase
  endfunction

  // one random sequence: mostly batches over a small pair pool, usually followed by a flush
  task automatic random_batch();
    logic [cewb_pkg::VERTEX_W-1:0] ps [6];
    logic [cewb_pkg::VERTEX_W-1:0] pd [6];
    int                            kind;
    int                            n;
    int                            npairs;
    int                            j;
    kind = $urandom_range(99);
    for (int i = 0; i < 6; i++) begin
      ps[i] = pick_id();
      pd[i] = pick_id();
    end
    if (kind < 65) begin
      n      = ($urandom_range(9) == 0) ? $urandom_range(28, 45) : $urandom_range(1, 12);
      npairs = $urandom_range(1, 6);
      repeat (n) begin
        j = $urandom_range(npairs - 1);
        send_edge(cewb_pkg::CMD_ENQUEUE, ps[j], pd[j], pick_weight(), 1'b0, NONE);
      end
      if ($urandom_range(4) != 0)
        send_edge(cewb_pkg::CMD_FLUSH, $urandom(), $urandom(), $urandom(), 1'b0, NONE);
    end else if (kind < 80) begin
      // run on one pair, drives the accumulator into its limits
      repeat ($urandom_range(2, 6))
        send_edge(cewb_pkg::CMD_ENQUEUE, ps[0], pd[0], pick_weight(), 1'b0, NONE);
    end else if (kind < 90) begin
      send_edge(cewb_pkg::CMD_FLUSH, $urandom(), $urandom(), $urandom(), 1'b0, NONE);
    end else begin
      send_edge(cewb_pkg::CMD_ENQUEUE, $urandom(), $urandom(), $urandom(), 1'b0, NONE);
    end
  endtask

  // output side: check each accepted item, drive ready
  always @(posedge clk) begin : result_side
    merged_edge_t got;
    merged_edge_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tdata[127:96], m_tlast};
      n_checked++;
      if (expected_edges.size() == 0) begin
        log_error($sformatf("unexpected edge: src %h dst %h weight %0d slot %0d last %b",
                            got.src, got.dst, got.weight, got.slot, got.last));
      end else begin
        want = expected_edges.pop_front();
        if (got.src !== want.src || got.dst !== want.dst || got.weight !== want.weight ||
            got.slot !== want.slot || got.last !== want.last)
          log_error($sformatf({"edge %0d: expected src %h dst %h weight %0d slot %0d last %b,",
                               " got src %h dst %h weight %0d slot %0d last %b"},
                              n_checked, want.src, want.dst, want.weight, want.slot,
                              want.last, got.src, got.dst, got.weight, got.slot, got.last));
      end
    end
    if (hold_ack != hold_req) begin
      hold_ack  = hold_req;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d edges still expected",
               n_cycles, expected_edges.size());
      $display("coalescing_edge_update_buffer regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    plan_row_t row;
    int        dir_items;
    int        done_items;
    bit        pressure_done;
    pressure_done = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int r = 0; r < PLAN_LEN; r++) begin
      row = PLAN[r];
      for (int i = 0; i < row.reps; i++)
        send_edge(row.cmd, row.src - i, row.dst + i, row.weight + i, row.typed, row.want);
    end
    dir_items = n_items;

    // random batches in four idling phases
    while (n_items < dir_items + RANDOM_ITEMS) begin
      done_items = n_items - dir_items;
      case (done_items * 4 / RANDOM_ITEMS)
        0: begin send_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; rcv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  rcv_stall_pct = 82; end
        default: begin send_idle_pct = 26; rcv_stall_pct = 26; end
      endcase
      // output held off while fresh edges keep coming: buffer fills, input stalls
      if (!pressure_done && done_items >= 40) begin
        pressure_done = 1'b1;
        hold_req++;
        repeat (40)
          send_edge(cewb_pkg::CMD_ENQUEUE, $urandom(), $urandom(), pick_weight(), 1'b0, NONE);
      end else begin
        random_batch();
      end
    end
    s_tvalid <= 1'b0;

    while (expected_edges.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items: %0d flush commands, %0d coalesced enqueues, %0d overflow flushes.",
             n_items, n_flush_cmd, n_coalesced, n_overflow);
    $display("Checked %0d merged edges, %0d mismatches.", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("coalescing_edge_update_buffer regression: pass");
    end else begin
      $display("coalescing_edge_update_buffer regression: fail");
    end
    $finish;
  end

endmodule

// ----- coalescing_edge_update_buffer.f -----
+incdir+sv
sv/cewb_pkg.sv
sv/cewb_entry_store.sv
sv/cewb_merge_unit.sv
sv/coalescing_edge_update_buffer.sv
sv/cewb_checker.sv
tb/sv/coalescing_edge_update_buffer_tb.sv
